// ===== hw/rtl/lpe_pkg.sv =====
// Shared types, constants and tables for the Legendre phi list-expansion block.
`default_nettype none
package lpe_pkg;

	localparam int unsigned LIST_DEPTH_DEF = 1024;
	localparam int unsigned MAX_A_DEF = 15;
	localparam int unsigned XW = 64;
	localparam int unsigned AIN_W = 4;
	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned M_TDATA_W = 64;
	localparam int unsigned DVW = 8;
	localparam int unsigned DIV_STEPS = 4;

	typedef enum logic [2:0] {
		DIV_P,
		DIV_2,
		DIV_3,
		DIV_6,
		DIV_30,
		DIV_210
	} div_sel_t;

	typedef enum logic [3:0] {
		ACC_HOLD,
		ACC_CLR,
		ACC_X,
		ACC_X_SUB_Q,
		ACC_SUB_Q,
		ACC_ADD_Q,
		ACC_MOD30,
		ACC_SMALL,
		ACC_ADD_F,
		ACC_SUB_F
	} acc_op_t;

	typedef struct packed {
		logic     load;
		logic     list_init;
		logic     pass_begin;
		logic     pass_src;
		logic     idx_inc;
		logic     k_dec;
		logic     div_start;
		logic     div_from_rd;
		div_sel_t div_sel;
		acc_op_t  acc_op;
		logic     wr_q;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic             div_busy;
		logic             div_done;
		logic             idx_lt_lim;
		logic             rd_ge_p;
		logic             dst_room;
		logic             k_gt4;
		logic             x_small;
		logic             src;
		logic             out_valid;
		logic [AIN_W-1:0] a_val;
	} status_t;

	localparam logic [5:0] PRIME_AT [17] = '{
		6'd0, 6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19,
		6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53
	};

	localparam logic [3:0] CNT30 [30] = '{
		4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2,
		4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6,
		4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8
	};

	localparam logic [5:0] CNT210 [210] = '{
		6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1,
		6'd1, 6'd2, 6'd2, 6'd3, 6'd3, 6'd3, 6'd3, 6'd4, 6'd4, 6'd5,
		6'd5, 6'd5, 6'd5, 6'd6, 6'd6, 6'd6, 6'd6, 6'd6, 6'd6, 6'd7,
		6'd7, 6'd8, 6'd8, 6'd8, 6'd8, 6'd8, 6'd8, 6'd9, 6'd9, 6'd9,
		6'd9, 6'd10, 6'd10, 6'd11, 6'd11, 6'd11, 6'd11, 6'd12, 6'd12, 6'd12,
		6'd12, 6'd12, 6'd12, 6'd13, 6'd13, 6'd13, 6'd13, 6'd13, 6'd13, 6'd14,
		6'd14, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15, 6'd16, 6'd16, 6'd16,
		6'd16, 6'd17, 6'd17, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18, 6'd19,
		6'd19, 6'd19, 6'd19, 6'd20, 6'd20, 6'd20, 6'd20, 6'd20, 6'd20, 6'd21,
		6'd21, 6'd21, 6'd21, 6'd21, 6'd21, 6'd21, 6'd21, 6'd22, 6'd22, 6'd22,
		6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd24, 6'd24, 6'd25, 6'd25, 6'd26,
		6'd26, 6'd26, 6'd26, 6'd27, 6'd27, 6'd27, 6'd27, 6'd27, 6'd27, 6'd27,
		6'd27, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd29, 6'd29, 6'd29,
		6'd29, 6'd30, 6'd30, 6'd30, 6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd32,
		6'd32, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd33, 6'd33, 6'd33, 6'd34,
		6'd34, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd36, 6'd36, 6'd36,
		6'd36, 6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd39,
		6'd39, 6'd39, 6'd39, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd41,
		6'd41, 6'd42, 6'd42, 6'd42, 6'd42, 6'd42, 6'd42, 6'd43, 6'd43, 6'd43,
		6'd43, 6'd44, 6'd44, 6'd45, 6'd45, 6'd45, 6'd45, 6'd46, 6'd46, 6'd47,
		6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd48
	};

endpackage
`default_nettype wire

// ===== hw/rtl/lpe_div.sv =====
// Iterative restoring divider of a 64-bit dividend by an 8-bit divisor.
`default_nettype none
module lpe_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [lpe_pkg::XW-1:0]       dividend,
	input  wire logic [lpe_pkg::DVW-1:0]      divisor,
	output logic                              busy,
	output logic                              done,
	output logic [lpe_pkg::XW-1:0]            quo,
	output logic [lpe_pkg::DVW-1:0]           rem
);

	localparam int unsigned NCYC = lpe_pkg::XW / lpe_pkg::DIV_STEPS;
	localparam int unsigned CNTW = $clog2(NCYC);

	logic [lpe_pkg::XW-1:0]  n_q;
	logic [lpe_pkg::DVW-1:0] r_q;
	logic [lpe_pkg::DVW-1:0] d_q;
	logic [CNTW-1:0]         cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [lpe_pkg::XW-1:0]  n_d;
	logic [lpe_pkg::DVW-1:0] r_d;

	always_comb begin
		logic [lpe_pkg::DVW:0] t;
		n_d = n_q;
		r_d = r_q;
		for (int s = 0; s < lpe_pkg::DIV_STEPS; s++) begin
			t = {r_d, n_d[lpe_pkg::XW-1]};
			n_d = {n_d[lpe_pkg::XW-2:0], 1'b0};
			if (t >= {1'b0, d_q}) begin
				t = t - {1'b0, d_q};
				n_d[0] = 1'b1;
			end
			r_d = t[lpe_pkg::DVW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(NCYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			n_q <= n_d;
			r_q <= r_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = n_q;
	assign rem = r_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lpe_dp.sv =====
// Datapath: operand registers, quotient lists, divider, accumulator and result register.
`default_nettype none
module lpe_dp #(
	parameter int unsigned LIST_DEPTH = lpe_pkg::LIST_DEPTH_DEF,
	parameter int unsigned MAX_A = lpe_pkg::MAX_A_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lpe_pkg::cmd_t                 cmd,
	input  wire logic [lpe_pkg::XW-1:0]        x_value,
	input  wire logic [lpe_pkg::AIN_W-1:0]     prime_count_a,
	input  wire logic                          out_ready,
	output lpe_pkg::status_t                   st,
	output logic                               out_valid,
	output logic [lpe_pkg::XW-1:0]             phi_result
);

	localparam int unsigned AW = $clog2(LIST_DEPTH);
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

	logic [lpe_pkg::XW-1:0]    x_q;
	logic [lpe_pkg::AIN_W-1:0] a_q;
	logic [lpe_pkg::AIN_W-1:0] k_q;
	logic [lpe_pkg::XW-1:0]    acc_q;
	logic [lpe_pkg::XW-1:0]    res_q;
	logic                      out_valid_q;
	logic [CW-1:0]             np_q;
	logic [CW-1:0]             nn_q;
	logic [CW-1:0]             lim_p_q;
	logic [CW-1:0]             lim_m_q;
	logic [CW-1:0]             idx_q;
	logic                      src_q;
	logic [lpe_pkg::XW-1:0]    plus_mem [LIST_DEPTH];
	logic [lpe_pkg::XW-1:0]    minus_mem [LIST_DEPTH];
	logic [lpe_pkg::XW-1:0]    rd_plus_q;
	logic [lpe_pkg::XW-1:0]    rd_minus_q;
	logic [lpe_pkg::XW-1:0]    rd;
	logic                      plus_we;
	logic [AW-1:0]             plus_wa;
	logic [lpe_pkg::XW-1:0]    plus_wd;
	logic                      minus_we;
	logic [lpe_pkg::DVW-1:0]   divisor;
	logic [lpe_pkg::XW-1:0]    quo;
	logic [lpe_pkg::DVW-1:0]   rem;
	logic                      div_busy;
	logic                      div_done;
	logic [5:0]                prime_k;
	logic [5:0]                prime_next;
	logic [lpe_pkg::AIN_W-1:0] a_clamped;

	assign a_clamped = (prime_count_a > lpe_pkg::AIN_W'(MAX_A)) ?
		lpe_pkg::AIN_W'(MAX_A) : prime_count_a;
	assign prime_k = lpe_pkg::PRIME_AT[{1'b0, k_q}];
	assign prime_next = lpe_pkg::PRIME_AT[{1'b0, a_q} + 5'd1];
	assign rd = src_q ? rd_minus_q : rd_plus_q;

	always_comb begin
		case (cmd.div_sel)
			lpe_pkg::DIV_P:   divisor = {2'b00, prime_k};
			lpe_pkg::DIV_2:   divisor = 8'd2;
			lpe_pkg::DIV_3:   divisor = 8'd3;
			lpe_pkg::DIV_6:   divisor = 8'd6;
			lpe_pkg::DIV_30:  divisor = 8'd30;
			lpe_pkg::DIV_210: divisor = 8'd210;
			default:          divisor = 8'd210;
		endcase
	end

	lpe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_from_rd ? rd : x_q),
		.divisor  (divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	always_comb begin
		plus_we = cmd.list_init || (cmd.wr_q && src_q);
		plus_wa = cmd.list_init ? '0 : np_q[AW-1:0];
		plus_wd = cmd.list_init ? x_q : quo;
		minus_we = cmd.wr_q && !src_q;
	end

	always_ff @(posedge clk) begin
		if (plus_we) begin
			plus_mem[plus_wa] <= plus_wd;
		end
		rd_plus_q <= plus_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (minus_we) begin
			minus_mem[nn_q[AW-1:0]] <= quo;
		end
		rd_minus_q <= minus_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			np_q <= '0;
			nn_q <= '0;
			lim_p_q <= '0;
			lim_m_q <= '0;
			idx_q <= '0;
			src_q <= 1'b0;
			k_q <= '0;
			a_q <= '0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				a_q <= a_clamped;
			end
			if (cmd.list_init) begin
				np_q <= CW'(1);
				nn_q <= '0;
				k_q <= a_q;
			end else if (cmd.wr_q) begin
				if (src_q) begin
					np_q <= np_q + 1'b1;
				end else begin
					nn_q <= nn_q + 1'b1;
				end
			end
			if (cmd.k_dec) begin
				k_q <= k_q - 1'b1;
			end
			if (cmd.pass_begin) begin
				idx_q <= '0;
				src_q <= cmd.pass_src;
				if (!cmd.pass_src) begin
					lim_p_q <= np_q;
					lim_m_q <= nn_q;
				end
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_value;
		end
		if (cmd.out_load) begin
			res_q <= acc_q;
		end
		case (cmd.acc_op)
			lpe_pkg::ACC_HOLD:    acc_q <= acc_q;
			lpe_pkg::ACC_CLR:     acc_q <= '0;
			lpe_pkg::ACC_X:       acc_q <= x_q;
			lpe_pkg::ACC_X_SUB_Q: acc_q <= x_q - quo;
			lpe_pkg::ACC_SUB_Q:   acc_q <= acc_q - quo;
			lpe_pkg::ACC_ADD_Q:   acc_q <= acc_q + quo;
			lpe_pkg::ACC_MOD30:   acc_q <= {quo[lpe_pkg::XW-4:0], 3'b000} +
				lpe_pkg::XW'(lpe_pkg::CNT30[rem[4:0]]);
			lpe_pkg::ACC_SMALL:   acc_q <= lpe_pkg::XW'(x_q != '0);
			lpe_pkg::ACC_ADD_F:   acc_q <= acc_q + {quo[lpe_pkg::XW-6:0], 5'd0} +
				{quo[lpe_pkg::XW-5:0], 4'd0} + lpe_pkg::XW'(lpe_pkg::CNT210[rem]);
			lpe_pkg::ACC_SUB_F:   acc_q <= acc_q - ({quo[lpe_pkg::XW-6:0], 5'd0} +
				{quo[lpe_pkg::XW-5:0], 4'd0} + lpe_pkg::XW'(lpe_pkg::CNT210[rem]));
			default:              acc_q <= acc_q;
		endcase
	end

	always_comb begin
		st.div_busy = div_busy;
		st.div_done = div_done;
		st.idx_lt_lim = idx_q < (src_q ? lim_m_q : lim_p_q);
		st.rd_ge_p = rd >= lpe_pkg::XW'(prime_k);
		st.dst_room = src_q ? (np_q < CW'(LIST_DEPTH)) : (nn_q < CW'(LIST_DEPTH));
		st.k_gt4 = k_q > lpe_pkg::AIN_W'(4);
		st.x_small = x_q < lpe_pkg::XW'(prime_next);
		st.src = src_q;
		st.out_valid = out_valid_q;
		st.a_val = a_q;
	end

	assign out_valid = out_valid_q;
	assign phi_result = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lpe_ctrl.sv =====
// Controller state machine that sequences the formula paths, list expansion and finish.
`default_nettype none
module lpe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              out_ready,
	input  wire lpe_pkg::status_t  st,
	output lpe_pkg::cmd_t          cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_W1,
		ST_W2A,
		ST_W2B,
		ST_W2C,
		ST_W3,
		ST_K_TOP,
		ST_P_ADDR,
		ST_P_DATA,
		ST_P_WAIT,
		ST_F_ADDR,
		ST_F_DATA,
		ST_F_WAIT,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_sel = lpe_pkg::DIV_P;
		cmd.acc_op = lpe_pkg::ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && ready_q) begin
					cmd.load = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				case (st.a_val)
					4'd0: begin
						cmd.acc_op = lpe_pkg::ACC_X;
						state_d = ST_OUT;
					end
					4'd1: begin
						cmd.div_start = 1'b1;
						cmd.div_sel = lpe_pkg::DIV_2;
						state_d = ST_W1;
					end
					4'd2: begin
						cmd.acc_op = lpe_pkg::ACC_X;
						cmd.div_start = 1'b1;
						cmd.div_sel = lpe_pkg::DIV_2;
						state_d = ST_W2A;
					end
					4'd3: begin
						cmd.div_start = 1'b1;
						cmd.div_sel = lpe_pkg::DIV_30;
						state_d = ST_W3;
					end
					default: begin
						if (st.x_small) begin
							cmd.acc_op = lpe_pkg::ACC_SMALL;
							state_d = ST_OUT;
						end else begin
							cmd.list_init = 1'b1;
							cmd.acc_op = lpe_pkg::ACC_CLR;
							state_d = ST_K_TOP;
						end
					end
				endcase
			end
			ST_W1: begin
				if (st.div_done) begin
					cmd.acc_op = lpe_pkg::ACC_X_SUB_Q;
					state_d = ST_OUT;
				end
			end
			ST_W2A: begin
				if (st.div_done) begin
					cmd.acc_op = lpe_pkg::ACC_SUB_Q;
					cmd.div_start = 1'b1;
					cmd.div_sel = lpe_pkg::DIV_3;
					state_d = ST_W2B;
				end
			end
			ST_W2B: begin
				if (st.div_done) begin
					cmd.acc_op = lpe_pkg::ACC_SUB_Q;
					cmd.div_start = 1'b1;
					cmd.div_sel = lpe_pkg::DIV_6;
					state_d = ST_W2C;
				end
			end
			ST_W2C: begin
				if (st.div_done) begin
					cmd.acc_op = lpe_pkg::ACC_ADD_Q;
					state_d = ST_OUT;
				end
			end
			ST_W3: begin
				if (st.div_done) begin
					cmd.acc_op = lpe_pkg::ACC_MOD30;
					state_d = ST_OUT;
				end
			end
			ST_K_TOP: begin
				cmd.pass_begin = 1'b1;
				state_d = st.k_gt4 ? ST_P_ADDR : ST_F_ADDR;
			end
			ST_P_ADDR: begin
				if (st.idx_lt_lim) begin
					state_d = ST_P_DATA;
				end else if (!st.src) begin
					cmd.pass_begin = 1'b1;
					cmd.pass_src = 1'b1;
				end else begin
					cmd.k_dec = 1'b1;
					state_d = ST_K_TOP;
				end
			end
			ST_P_DATA: begin
				if (st.rd_ge_p && st.dst_room) begin
					cmd.div_start = 1'b1;
					cmd.div_from_rd = 1'b1;
					state_d = ST_P_WAIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = ST_P_ADDR;
				end
			end
			ST_P_WAIT: begin
				if (st.div_done) begin
					cmd.wr_q = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d = ST_P_ADDR;
				end
			end
			ST_F_ADDR: begin
				if (st.idx_lt_lim) begin
					state_d = ST_F_DATA;
				end else if (!st.src) begin
					cmd.pass_begin = 1'b1;
					cmd.pass_src = 1'b1;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_F_DATA: begin
				cmd.div_start = 1'b1;
				cmd.div_from_rd = 1'b1;
				cmd.div_sel = lpe_pkg::DIV_210;
				state_d = ST_F_WAIT;
			end
			ST_F_WAIT: begin
				if (st.div_done) begin
					cmd.acc_op = st.src ? lpe_pkg::ACC_SUB_F : lpe_pkg::ACC_ADD_F;
					cmd.idx_inc = 1'b1;
					state_d = ST_F_ADDR;
				end
			end
			ST_OUT: begin
				if (!st.out_valid || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == ST_IDLE);
		end
	end

	assign in_ready = ready_q;

endmodule
`default_nettype wire

// ===== hw/rtl/legendre_phi_list_expand.sv =====
// Top level of the Legendre phi block: stream ports, controller and datapath.
`default_nettype none
// Computes phi(x, a), the count of integers up to x coprime to the first a primes, one
// transaction at a time. Every division goes through one shared divider that retires four
// quotient bits a cycle. For a of zero, and for a of 4 or more with x below the next prime,
// the result needs no division; for a of 1 to 3 it takes one to three divisions.
// Otherwise a quotient list is built in two list memories and then finished: in the build each
// list entry is examined and divided by the prime when it is at least that prime and its
// destination list has room, and in the finish each entry is divided by 210; at the default
// depth the lists hold up to 2048 entries. The result register lets the next transaction in
// while the previous result still waits.
module legendre_phi_list_expand #(
	parameter int unsigned LIST_DEPTH = lpe_pkg::LIST_DEPTH_DEF,
	parameter int unsigned MAX_A = lpe_pkg::MAX_A_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// Fields from bit 0: x_value[63:0], prime_count_a[67:64], zero fill.
	input  wire logic [lpe_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// Fields from bit 0: phi_result[63:0].
	output logic [lpe_pkg::M_TDATA_W-1:0]            m_tdata
);

	lpe_pkg::cmd_t    cmd;
	lpe_pkg::status_t st;

	lpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.st        (st),
		.cmd       (cmd)
	);

	lpe_dp #(
		.LIST_DEPTH (LIST_DEPTH),
		.MAX_A      (MAX_A)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.x_value       (s_tdata[lpe_pkg::XW-1:0]),
		.prime_count_a (s_tdata[lpe_pkg::XW +: lpe_pkg::AIN_W]),
		.out_ready     (m_tready),
		.st            (st),
		.out_valid     (m_tvalid),
		.phi_result    (m_tdata)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a transaction is in progress");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !s_tready)
		else $error("result loaded without a transaction in progress");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy)
		else $error("divider started while busy");

	a_write_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_q |-> st.dst_room)
		else $error("list write beyond its depth");
`endif

endmodule
`default_nettype wire

// ===== dv/lpe_checker.sv =====
// Checker for the Legendre phi block: predicts phi(x, a) and compares results.
`default_nettype none
module lpe_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [71:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [63:0] m_tdata,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = lpe_pkg::LIST_DEPTH_DEF;

	logic [63:0] phi_expected[$];

	function automatic logic [63:0] coprime210_count(logic [63:0] v);
		return (v / 64'd210) * 64'd48 + 64'(lpe_pkg::CNT210[v % 64'd210]);
	endfunction

	function automatic logic [63:0] phi_of(logic [63:0] x, logic [3:0] a);
		logic [63:0] pos_q[$];
		logic [63:0] neg_q[$];
		logic [63:0] p;
		logic [63:0] sum;
		int op;
		int on;
		sum = '0;
		case (a)
			4'd0: return x;
			4'd1: return x - x / 2;
			4'd2: return x - x / 2 - x / 3 + x / 6;
			4'd3: return (x / 30) * 8 + 64'(lpe_pkg::CNT30[x % 30]);
			default: ;
		endcase
		if (x < 64'(lpe_pkg::PRIME_AT[a + 1])) return (x != 0) ? 64'd1 : 64'd0;
		pos_q.push_back(x);
		for (int k = a; k > 4; k--) begin
			p = 64'(lpe_pkg::PRIME_AT[k]);
			op = pos_q.size();
			on = neg_q.size();
			for (int i = 0; i < op; i++)
				if (pos_q[i] >= p && neg_q.size() < DEPTH) neg_q.push_back(pos_q[i] / p);
			for (int i = 0; i < on; i++)
				if (neg_q[i] >= p && pos_q.size() < DEPTH) pos_q.push_back(neg_q[i] / p);
		end
		foreach (pos_q[i]) sum += coprime210_count(pos_q[i]);
		foreach (neg_q[i]) sum -= coprime210_count(neg_q[i]);
		return sum;
	endfunction

	assign pending = phi_expected.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				phi_expected.push_back(phi_of(s_tdata[63:0], s_tdata[67:64]));
			if (m_tvalid && m_tready) begin
				if (phi_expected.size() == 0) begin
					$display("%0t: unexpected result, actual %0d", $time, m_tdata);
					fail_count++;
				end else begin
					if (m_tdata !== phi_expected[0]) begin
						$display("%0t: phi mismatch, expected %0d, actual %0d",
							$time, phi_expected[0], m_tdata);
						fail_count++;
					end
					void'(phi_expected.pop_front());
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench top for the Legendre phi block: stimulus, idling and verdict.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	int          fail_count;
	int          pending;
	int          send_idle;
	int          recv_idle;
	int          results_seen;

	legendre_phi_list_expand u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	lpe_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("tb_top: errors");
		$finish;
	end

	always @(posedge clk) if (m_tvalid && m_tready) results_seen++;

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (results_seen == 30) begin
				m_tready <= 1'b0;
				for (int n = 0; n < 3000; n++) @(negedge clk);
				results_seen++;
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic send_item(logic [63:0] x, logic [3:0] a);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, a, x};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		logic [63:0] x;
		logic [3:0] a;
		int w;
		s_tvalid = 1'b0;
		s_tdata = '0;
		results_seen = 0;
		send_idle = 7;
		recv_idle = 67;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < 16; i++) send_item((i % 2) ? '1 : 64'd0, 4'(i));
		send_item(64'd52, 4'd15);
		send_item(64'd53, 4'd15);
		send_item(64'd10, 4'd4);
		send_item(64'd11, 4'd4);
		send_item(64'd1, 4'd9);
		send_item(64'd209, 4'd5);
		send_item(64'd210, 4'd6);
		send_item(64'd29, 4'd3);
		wait_drained();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 7 : (ph == 1) ? 67 : 0;
			recv_idle = (ph == 0) ? 67 : (ph == 1) ? 7 : 0;
			for (int i = 0; i < 39; i++) begin
				a = 4'($urandom_range(0, 15));
				w = (a >= 13) ? $urandom_range(1, 24) : $urandom_range(1, 64);
				x = {$urandom, $urandom};
				if (w < 64) x = x & ((64'd1 << w) - 1);
				send_item(x, a);
			end
			wait_drained();
		end
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== legendre_phi_list_expand.f =====
hw/rtl/lpe_pkg.sv
hw/rtl/lpe_div.sv
hw/rtl/lpe_dp.sv
hw/rtl/lpe_ctrl.sv
hw/rtl/legendre_phi_list_expand.sv
dv/lpe_checker.sv
dv/tb_top.sv
